/* design/ctok_pkg.sv */
`timescale 1ns / 1ps

package ctok_pkg;

    // input item: one source byte or the end of text
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_flag;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [1:0] item_kind;
        logic [1:0] token_kind;
        logic [7:0] char_value;
        logic       first_char;
        logic [1:0] error_code;
        logic       last_of_run;
    } result_t;

    localparam int MaxResults = 4;

    // burst of results caused by one input item
    typedef struct packed {
        result_t [MaxResults-1:0] r;
        logic [2:0]               n;
    } burst_t;

    // item kinds
    localparam logic [1:0] IK_CHAR = 2'd0;
    localparam logic [1:0] IK_END  = 2'd1;
    localparam logic [1:0] IK_ERR  = 2'd2;

    // token kinds
    localparam logic [1:0] TK_IDENT  = 2'd0;
    localparam logic [1:0] TK_NUMBER = 2'd1;
    localparam logic [1:0] TK_STRING = 2'd2;
    localparam logic [1:0] TK_OP     = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_SECOND_DOT = 2'd1;
    localparam logic [1:0] ERR_BAD_ESC   = 2'd2;
    localparam logic [1:0] ERR_OPEN_STR  = 2'd3;

    // characters with meaning to the lexer
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic result_t mk_result(input logic [1:0] kind, input logic [1:0] tk,
                                          input logic [7:0] ch, input logic first,
                                          input logic [1:0] err);
        result_t r;
        r.item_kind   = kind;
        r.token_kind  = tk;
        r.char_value  = ch;
        r.first_char  = first;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

/* design/ctok_lexer.sv */
`timescale 1ns / 1ps

module ctok_lexer import ctok_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step_en,
    input  in_item_t in_item,
    output burst_t   burst
);

    typedef enum logic [11:0] {
        M_IDLE      = 12'b0000_0000_0001,
        M_IDENT     = 12'b0000_0000_0010,
        M_NUMBER    = 12'b0000_0000_0100,
        M_STR_EMPTY = 12'b0000_0000_1000,
        M_STR       = 12'b0000_0001_0000,
        M_ESC_EMPTY = 12'b0000_0010_0000,
        M_ESC       = 12'b0000_0100_0000,
        M_SLASH     = 12'b0000_1000_0000,
        M_COLON     = 12'b0001_0000_0000,
        M_LINE_CMT  = 12'b0010_0000_0000,
        M_BLK_CMT   = 12'b0100_0000_0000,
        M_BLK_STAR  = 12'b1000_0000_0000
    } mode_t;

    // outcome of a byte seen between tokens
    typedef struct packed {
        mode_t      mode;
        logic       clr_dot;
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } start_t;

    mode_t mode_reg, mode_next;
    logic  dot_reg, dot_next;

    function automatic start_t start_token(input logic [7:0] c);
        start_t s;
        s.mode    = M_IDLE;
        s.clr_dot = 1'b0;
        s.n       = 2'd0;
        s.r0      = '0;
        s.r1      = '0;
        if (is_space(c)) begin
            s.mode = M_IDLE;
        end else if (c == CH_UNDER || is_alpha(c)) begin
            s.r0   = mk_result(IK_CHAR, TK_IDENT, c, 1'b1, ERR_NONE);
            s.n    = 2'd1;
            s.mode = M_IDENT;
        end else if (c == CH_PLUS || c == CH_MINUS || is_digit(c)) begin
            s.r0      = mk_result(IK_CHAR, TK_NUMBER, c, 1'b1, ERR_NONE);
            s.n       = 2'd1;
            s.clr_dot = 1'b1;
            s.mode    = M_NUMBER;
        end else if (c == CH_QUOTE) begin
            s.mode = M_STR_EMPTY;
        end else if (c == CH_SLASH) begin
            s.mode = M_SLASH;
        end else if (c == CH_COLON) begin
            s.mode = M_COLON;
        end else begin
            s.r0 = mk_result(IK_CHAR, TK_OP, c, 1'b1, ERR_NONE);
            s.r1 = mk_result(IK_END, TK_OP, 8'h00, 1'b0, ERR_NONE);
            s.n  = 2'd2;
        end
        return s;
    endfunction

    // escape translation, valid flag in the top bit
    function automatic logic [8:0] escape_of(input logic [7:0] c);
        logic [8:0] e;
        case (c)
            CH_BSLASH, CH_SLASH, CH_QUOTE: e = {1'b1, c};
            8'h62:   e = {1'b1, 8'h08};
            8'h66:   e = {1'b1, 8'h0C};
            8'h6E:   e = {1'b1, 8'h0A};
            8'h72:   e = {1'b1, 8'h0D};
            8'h74:   e = {1'b1, 8'h09};
            default: e = 9'h000;
        endcase
        return e;
    endfunction

    // next state and the results of this item
    always_comb begin
        logic [7:0]  c;
        logic [2:0]  n;
        logic [2:0]  last_idx;
        logic        do_start;
        logic        empty;
        logic [8:0]  esc;
        start_t      st;
        result_t [MaxResults-1:0] res;

        c         = in_item.text_byte;
        n         = 3'd0;
        res       = '0;
        do_start  = 1'b0;
        mode_next = mode_reg;
        dot_next  = dot_reg;
        empty     = (mode_reg == M_STR_EMPTY) || (mode_reg == M_ESC_EMPTY);
        esc       = escape_of(c);
        st        = start_token(c);
        last_idx  = 3'd0;

        if (in_item.end_flag) begin
            unique case (mode_reg)
                M_IDENT: begin
                    res[0] = mk_result(IK_END, TK_IDENT, 8'h00, 1'b0, ERR_NONE);
                    n = 3'd1;
                end
                M_NUMBER: begin
                    res[0] = mk_result(IK_END, TK_NUMBER, 8'h00, 1'b0, ERR_NONE);
                    n = 3'd1;
                end
                M_STR_EMPTY, M_STR, M_ESC_EMPTY, M_ESC: begin
                    res[0] = mk_result(IK_ERR, TK_STRING, 8'h00, 1'b0, ERR_OPEN_STR);
                    n = 3'd1;
                end
                M_SLASH: begin
                    res[0] = mk_result(IK_CHAR, TK_OP, CH_SLASH, 1'b1, ERR_NONE);
                    res[1] = mk_result(IK_END, TK_OP, 8'h00, 1'b0, ERR_NONE);
                    n = 3'd2;
                end
                M_COLON: begin
                    res[0] = mk_result(IK_CHAR, TK_OP, CH_COLON, 1'b1, ERR_NONE);
                    res[1] = mk_result(IK_END, TK_OP, 8'h00, 1'b0, ERR_NONE);
                    n = 3'd2;
                end
                default: n = 3'd0;
            endcase
            mode_next = M_IDLE;
            dot_next  = 1'b0;
        end else begin
            unique case (mode_reg)
                M_IDENT: begin
                    if (c == CH_UNDER || is_alpha(c) || is_digit(c)) begin
                        res[0] = mk_result(IK_CHAR, TK_IDENT, c, 1'b0, ERR_NONE);
                        n = 3'd1;
                    end else begin
                        res[0] = mk_result(IK_END, TK_IDENT, 8'h00, 1'b0, ERR_NONE);
                        n = 3'd1;
                        do_start = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (c == CH_DOT) begin
                        if (dot_reg) begin
                            res[0] = mk_result(IK_ERR, TK_NUMBER, c, 1'b0, ERR_SECOND_DOT);
                        end else begin
                            res[0] = mk_result(IK_CHAR, TK_NUMBER, c, 1'b0, ERR_NONE);
                            dot_next = 1'b1;
                        end
                        n = 3'd1;
                    end else if (is_digit(c)) begin
                        res[0] = mk_result(IK_CHAR, TK_NUMBER, c, 1'b0, ERR_NONE);
                        n = 3'd1;
                    end else begin
                        res[0] = mk_result(IK_END, TK_NUMBER, 8'h00, 1'b0, ERR_NONE);
                        n = 3'd1;
                        do_start = 1'b1;
                    end
                end
                M_STR_EMPTY, M_STR: begin
                    if (c == CH_BSLASH) begin
                        mode_next = empty ? M_ESC_EMPTY : M_ESC;
                    end else if (c == CH_QUOTE) begin
                        res[0] = mk_result(IK_END, TK_STRING, 8'h00, 1'b0, ERR_NONE);
                        n = 3'd1;
                        mode_next = M_IDLE;
                    end else begin
                        res[0] = mk_result(IK_CHAR, TK_STRING, c, empty, ERR_NONE);
                        n = 3'd1;
                        mode_next = M_STR;
                    end
                end
                M_ESC_EMPTY, M_ESC: begin
                    if (!esc[8]) begin
                        res[0] = mk_result(IK_ERR, TK_STRING, c, 1'b0, ERR_BAD_ESC);
                        mode_next = empty ? M_STR_EMPTY : M_STR;
                    end else begin
                        res[0] = mk_result(IK_CHAR, TK_STRING, esc[7:0], empty, ERR_NONE);
                        mode_next = M_STR;
                    end
                    n = 3'd1;
                end
                M_SLASH: begin
                    if (c == CH_STAR) begin
                        mode_next = M_BLK_CMT;
                    end else if (c == CH_SLASH) begin
                        mode_next = M_LINE_CMT;
                    end else begin
                        res[0] = mk_result(IK_CHAR, TK_OP, CH_SLASH, 1'b1, ERR_NONE);
                        res[1] = mk_result(IK_END, TK_OP, 8'h00, 1'b0, ERR_NONE);
                        n = 3'd2;
                        do_start = 1'b1;
                    end
                end
                M_COLON: begin
                    res[0] = mk_result(IK_CHAR, TK_OP, CH_COLON, 1'b1, ERR_NONE);
                    if (c == CH_COLON) begin
                        res[1] = mk_result(IK_CHAR, TK_OP, CH_COLON, 1'b0, ERR_NONE);
                        res[2] = mk_result(IK_END, TK_OP, 8'h00, 1'b0, ERR_NONE);
                        n = 3'd3;
                        mode_next = M_IDLE;
                    end else begin
                        res[1] = mk_result(IK_END, TK_OP, 8'h00, 1'b0, ERR_NONE);
                        n = 3'd2;
                        do_start = 1'b1;
                    end
                end
                M_LINE_CMT: begin
                    if (c == CH_LF) mode_next = M_IDLE;
                end
                M_BLK_CMT: begin
                    if (c == CH_STAR) mode_next = M_BLK_STAR;
                end
                M_BLK_STAR: begin
                    if (c == CH_SLASH) mode_next = M_IDLE;
                    else if (c != CH_STAR) mode_next = M_BLK_CMT;
                end
                default: do_start = 1'b1;
            endcase

            // byte that opens the next token
            if (do_start) begin
                mode_next = st.mode;
                if (st.clr_dot) dot_next = 1'b0;
                if (st.n != 2'd0) begin
                    res[n[1:0]] = st.r0;
                    n = n + 3'd1;
                end
                if (st.n == 2'd2) begin
                    res[n[1:0]] = st.r1;
                    n = n + 3'd1;
                end
            end
        end

        // flag the final result of the run
        if (n != 3'd0) begin
            last_idx = n - 3'd1;
            res[last_idx[1:0]].last_of_run = 1'b1;
        end

        burst.r = res;
        burst.n = n;
    end

    // lexer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            dot_reg  <= 1'b0;
        end else if (step_en) begin
            mode_reg <= mode_next;
            dot_reg  <= dot_next;
        end
    end

endmodule

/* design/ctok_out_buf.sv */
`timescale 1ns / 1ps

module ctok_out_buf import ctok_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  burst_t  burst,
    output logic    can_load,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    result_t [MaxResults-1:0] res_reg;
    logic [2:0] cnt_reg;
    logic [1:0] rd_reg;

    assign m_valid  = cnt_reg != 3'd0;
    assign m_data   = res_reg[rd_reg];
    // room for a new burst once the last held item leaves
    assign can_load = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_ready);

    // burst payload
    always_ff @(posedge aclk) begin
        if (load) res_reg <= burst.r;
    end

    // fill count and read pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
            rd_reg  <= 2'd0;
        end else if (load) begin
            cnt_reg <= burst.n;
            rd_reg  <= 2'd0;
        end else if (m_valid && m_ready) begin
            cnt_reg <= cnt_reg - 3'd1;
            rd_reg  <= rd_reg + 2'd1;
        end
    end

endmodule

/* design/c_like_source_tokenizer_top.sv */
`timescale 1ns / 1ps
// the first result of an item is valid in the cycle after the item is accepted
// throughput: one item per cycle while each item gives at most one result and m_ready is high;
// an item that gives k results holds the output buffer until all k results are taken
// reset: aresetn low clears the lexer to idle between tokens, clears the dot flag
// and empties the result buffer
module c_like_source_tokenizer_top import ctok_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output result_t  m_data
);

    burst_t burst;
    logic   can_load;
    logic   step_en;

    assign s_ready = can_load;
    assign step_en = s_valid && s_ready;

    // state and result decode
    ctok_lexer u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .in_item (s_data),
        .burst   (burst)
    );

    // result register and serializer
    ctok_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step_en),
        .burst    (burst),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
